/* rtl/core/knnlu_pkg.sv */
// Shared types, codes and field layout for the pruned k-nearest-neighbour list keeper.
`timescale 1ns / 1ps
`default_nettype none

package knnlu_pkg;

    // Field widths of one input word and one result word
    localparam int OP_W      = 3;
    localparam int PIX_W     = 12;
    localparam int ELEM_W    = 5;
    localparam int IN_VAL_W  = 16;
    localparam int ERR_W     = 32;
    localparam int MAP_W     = 12;
    localparam int OUTC_W    = 2;

    // Input tdata layout, lowest field first
    localparam int S_PIX_LSB  = 0;
    localparam int S_CAND_LSB = S_PIX_LSB + PIX_W;
    localparam int S_ELEM_LSB = S_CAND_LSB + PIX_W;
    localparam int S_VAL_LSB  = S_ELEM_LSB + ELEM_W;
    localparam int S_ERR_LSB  = S_VAL_LSB + IN_VAL_W;
    localparam int S_MAP_LSB  = S_ERR_LSB + ERR_W;
    localparam int S_TDATA_W  = 96;
    localparam int M_TDATA_W  = 80;
    localparam int M_PAD_W    = M_TDATA_W - (1 + ERR_W + ERR_W + MAP_W);

    // Configuration registers
    localparam int NK_REG_W   = 6;
    localparam int K_REG_W    = 5;
    localparam int DIM_REG_W  = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_KERNELS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBOUR_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH     = 2'd3;

    // Operation codes
    localparam logic [OP_W-1:0] OP_WRITE_A    = 3'd0;
    localparam logic [OP_W-1:0] OP_WRITE_B    = 3'd1;
    localparam logic [OP_W-1:0] OP_WRITE_LIST = 3'd2;
    localparam logic [OP_W-1:0] OP_EVALUATE   = 3'd3;
    localparam logic [OP_W-1:0] OP_READ       = 3'd4;

    // Outcome codes
    localparam logic [OUTC_W-1:0] OUT_NONE      = 2'd0;
    localparam logic [OUTC_W-1:0] OUT_DUPLICATE = 2'd1;
    localparam logic [OUTC_W-1:0] OUT_PRUNED    = 2'd2;
    localparam logic [OUTC_W-1:0] OUT_INSERTED  = 2'd3;

    // Remainder unit: one bit of the pixel index per step
    localparam int MOD_CNT_W = 4;
    localparam logic [MOD_CNT_W-1:0] MOD_STEPS = 4'd12;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_READ_WAIT,
        S_QSCAN,
        S_QCHECK,
        S_TERMS,
        S_QPLACE_W,
        S_QPLACE_F,
        S_MOD,
        S_BORDER,
        S_CSCAN,
        S_CCHECK,
        S_CPLACE_W,
        S_CPLACE_F,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              accept;
        logic              wr_proj;
        logic              wr_list;
        logic              rd_issue;
        logic              rd_capture;
        logic              scan_start;
        logic              scan_run;
        logic              scan_cand;
        logic              term_start;
        logic              term_run;
        logic              place_worst;
        logic              place_first;
        logic              mod_start;
        logic              mod_run;
        logic              set_outcome;
        logic [OUTC_W-1:0] outcome;
        logic              set_inv;
        logic              out_load;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            eval_ok;
        logic            scan_done;
        logic            dup;
        logic            term_over;
        logic            term_fin;
        logic            mod_done;
        logic            border;
        logic            dist_over;
        logic            out_free;
    } t_sts;

endpackage

`default_nettype wire

/* rtl/core/knnlu_ram.sv */
// Generic single-write, single-read memory with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module knnlu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write and one registered read each cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/core/knnlu_ctrl.sv */
// Sequencer for the list keeper: dispatches each word and steps the datapath phases.
`timescale 1ns / 1ps
`default_nettype none

module knnlu_ctrl
    import knnlu_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_s_tvalid,
    input  wire t_sts i_sts,
    output logic      o_s_tready,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_sts.op)
                    OP_WRITE_A, OP_WRITE_B: begin
                        o_cmd.wr_proj = 1'b1;
                        n_state       = S_DONE;
                    end
                    OP_WRITE_LIST: begin
                        o_cmd.wr_list = 1'b1;
                        n_state       = S_DONE;
                    end
                    OP_READ: begin
                        o_cmd.rd_issue = 1'b1;
                        n_state        = S_READ_WAIT;
                    end
                    OP_EVALUATE: begin
                        if (i_sts.eval_ok) begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = S_QSCAN;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_READ_WAIT: begin
                o_cmd.rd_capture = 1'b1;
                n_state          = S_DONE;
            end
            S_QSCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_QCHECK;
                end
            end
            S_QCHECK: begin
                if (i_sts.dup) begin
                    o_cmd.set_outcome = 1'b1;
                    o_cmd.outcome     = OUT_DUPLICATE;
                    n_state           = S_DONE;
                end else begin
                    o_cmd.term_start = 1'b1;
                    n_state          = S_TERMS;
                end
            end
            S_TERMS: begin
                o_cmd.term_run = 1'b1;
                if (i_sts.term_over) begin
                    o_cmd.set_outcome = 1'b1;
                    o_cmd.outcome     = OUT_PRUNED;
                    n_state           = S_DONE;
                end else if (i_sts.term_fin) begin
                    n_state = S_QPLACE_W;
                end
            end
            S_QPLACE_W: begin
                o_cmd.place_worst = 1'b1;
                n_state           = S_QPLACE_F;
            end
            S_QPLACE_F: begin
                o_cmd.place_first = 1'b1;
                o_cmd.set_outcome = 1'b1;
                o_cmd.outcome     = OUT_INSERTED;
                o_cmd.mod_start   = 1'b1;
                n_state           = S_MOD;
            end
            S_MOD: begin
                if (i_sts.mod_done) begin
                    n_state = S_BORDER;
                end else begin
                    o_cmd.mod_run = 1'b1;
                end
            end
            S_BORDER: begin
                if (i_sts.border) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    o_cmd.scan_cand  = 1'b1;
                    n_state          = S_CSCAN;
                end
            end
            S_CSCAN: begin
                o_cmd.scan_run  = 1'b1;
                o_cmd.scan_cand = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_CCHECK;
                end
            end
            S_CCHECK: begin
                o_cmd.scan_cand = 1'b1;
                if (i_sts.dup || i_sts.dist_over) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_CPLACE_W;
                end
            end
            S_CPLACE_W: begin
                o_cmd.place_worst = 1'b1;
                o_cmd.scan_cand   = 1'b1;
                n_state           = S_CPLACE_F;
            end
            S_CPLACE_F: begin
                o_cmd.place_first = 1'b1;
                o_cmd.scan_cand   = 1'b1;
                o_cmd.set_inv     = 1'b1;
                n_state           = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/knnlu_dpath.sv */
// Datapath: stores, list scans, squared-difference accumulator, remainder unit, result word.
`timescale 1ns / 1ps
`default_nettype none

module knnlu_dpath
    import knnlu_pkg::*;
#(
    parameter int PIXELS         = 4096,
    parameter int MAX_KERNELS    = 32,
    parameter int MAX_NEIGHBOURS = 16,
    parameter int VALUE_WIDTH    = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [S_TDATA_W-1:0]  i_s_tdata,
    input  wire logic [OP_W-1:0]       i_s_tuser,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_m_tready,
    input  wire t_cmd                  i_cmd,
    output t_sts                       o_sts,
    output logic                       o_m_tvalid,
    output logic [M_TDATA_W-1:0]       o_m_tdata,
    output logic [OUTC_W-1:0]          o_m_tuser
);

    localparam int PA_W    = $clog2(PIXELS * MAX_KERNELS);
    localparam int LA_W    = $clog2(PIXELS * MAX_NEIGHBOURS);
    localparam int TC_W    = $clog2(MAX_KERNELS + 1);
    localparam int TI_W    = $clog2(MAX_KERNELS);
    localparam int SC_W    = $clog2(MAX_NEIGHBOURS + 1);
    localparam int SI_W    = $clog2(MAX_NEIGHBOURS);
    localparam int MAG_W   = VALUE_WIDTH + 1;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int ACC_RAW = SQ_W + $clog2(MAX_KERNELS) + 1;
    localparam int ACC_W   = (ACC_RAW > ERR_W + 1) ? ACC_RAW : ERR_W + 1;
    localparam int HW_W    = 2 * DIM_REG_W;

    // Address of an element in a per-pixel row
    function automatic logic [PA_W-1:0] pa_addr(input logic [PIX_W-1:0] pix,
                                                input logic [PA_W-1:0]  idx);
        return PA_W'(pix) * PA_W'(MAX_KERNELS) + idx;
    endfunction

    function automatic logic [LA_W-1:0] la_addr(input logic [PIX_W-1:0] pix,
                                                input logic [LA_W-1:0]  idx);
        return LA_W'(pix) * LA_W'(MAX_NEIGHBOURS) + idx;
    endfunction

    // Configuration registers
    logic [NK_REG_W-1:0]  r_nk;
    logic [K_REG_W-1:0]   r_k;
    logic [DIM_REG_W-1:0] r_h;
    logic [DIM_REG_W-1:0] r_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nk <= NK_REG_W'(16);
            r_k  <= K_REG_W'(4);
            r_h  <= DIM_REG_W'(64);
            r_w  <= DIM_REG_W'(64);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ACTIVE_KERNELS:  r_nk <= i_cfg_data[NK_REG_W-1:0];
                CFG_NEIGHBOUR_COUNT: r_k  <= i_cfg_data[K_REG_W-1:0];
                CFG_IMAGE_HEIGHT:    r_h  <= i_cfg_data[DIM_REG_W-1:0];
                CFG_IMAGE_WIDTH:     r_w  <= i_cfg_data[DIM_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // Registers clamped to their working ranges
    logic [TC_W-1:0]      nk_eff;
    logic [SC_W-1:0]      k_eff;
    logic [DIM_REG_W-1:0] h_eff;
    logic [DIM_REG_W-1:0] w_m1;
    logic [HW_W-1:0]      r_hw;

    always_comb begin
        if (r_nk == '0) begin
            nk_eff = TC_W'(1);
        end else if (32'(r_nk) > MAX_KERNELS) begin
            nk_eff = TC_W'(MAX_KERNELS);
        end else begin
            nk_eff = TC_W'(r_nk);
        end
        if (r_k < K_REG_W'(2)) begin
            k_eff = SC_W'(2);
        end else if (32'(r_k) > MAX_NEIGHBOURS) begin
            k_eff = SC_W'(MAX_NEIGHBOURS);
        end else begin
            k_eff = SC_W'(r_k);
        end
        h_eff = (r_h == '0) ? DIM_REG_W'(1) : r_h;
        w_m1  = ((r_w == '0) ? DIM_REG_W'(1) : r_w) - DIM_REG_W'(1);
    end

    // Height times (width - 1): pixel indices above this lie on the far border
    always_ff @(posedge i_clk) begin
        r_hw <= HW_W'(h_eff) * HW_W'(w_m1);
    end

    // Latched input word
    logic [OP_W-1:0]        r_op;
    logic [PIX_W-1:0]       r_p;
    logic [PIX_W-1:0]       r_c;
    logic [ELEM_W-1:0]      r_e;
    logic [VALUE_WIDTH-1:0] r_val;
    logic [ERR_W-1:0]       r_ierr;
    logic [MAP_W-1:0]       r_imap;
    logic [31:0]            in_val32;

    assign in_val32 = {{(32 - IN_VAL_W){i_s_tdata[S_VAL_LSB + IN_VAL_W - 1]}},
                       i_s_tdata[S_VAL_LSB +: IN_VAL_W]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op   <= i_s_tuser;
            r_p    <= i_s_tdata[S_PIX_LSB +: PIX_W];
            r_c    <= i_s_tdata[S_CAND_LSB +: PIX_W];
            r_e    <= i_s_tdata[S_ELEM_LSB +: ELEM_W];
            r_val  <= in_val32[VALUE_WIDTH-1:0];
            r_ierr <= i_s_tdata[S_ERR_LSB +: ERR_W];
            r_imap <= i_s_tdata[S_MAP_LSB +: MAP_W];
        end
    end

    logic p_ok, c_ok, ek_ok, en_ok;
    assign p_ok  = 32'(r_p) < PIXELS;
    assign c_ok  = 32'(r_c) < PIXELS;
    assign ek_ok = 32'(r_e) < MAX_KERNELS;
    assign en_ok = 32'(r_e) < MAX_NEIGHBOURS;

    // Projection stores
    logic                   a_we, b_we;
    logic [PA_W-1:0]        proj_waddr, a_raddr, b_raddr;
    logic [VALUE_WIDTH-1:0] a_rd, b_rd;
    logic [TC_W-1:0]        r_t;

    assign a_we       = i_cmd.wr_proj && (r_op == OP_WRITE_A) && p_ok && ek_ok;
    assign b_we       = i_cmd.wr_proj && (r_op == OP_WRITE_B) && p_ok && ek_ok;
    assign proj_waddr = pa_addr(r_p, PA_W'(r_e));
    assign a_raddr    = pa_addr(r_p, PA_W'(r_t[TI_W-1:0]));
    assign b_raddr    = pa_addr(r_c, PA_W'(r_t[TI_W-1:0]));

    knnlu_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(PIXELS * MAX_KERNELS)) u_proj_a (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (proj_waddr),
        .i_wdata (r_val),
        .i_raddr (a_raddr),
        .o_rdata (a_rd)
    );

    knnlu_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(PIXELS * MAX_KERNELS)) u_proj_b (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (proj_waddr),
        .i_wdata (r_val),
        .i_raddr (b_raddr),
        .o_rdata (b_rd)
    );

    // List stores: error and mapping share their addresses
    logic [PIX_W-1:0]  base_pix, target_pix;
    logic [SC_W-1:0]   r_si;
    logic [SI_W-1:0]   r_wi;
    logic [ERR_W-1:0]  r_e0;
    logic [MAP_W-1:0]  r_m0;
    logic [ACC_W-1:0]  r_acc;
    logic [ERR_W-1:0]  full_dist;
    logic              list_we;
    logic [LA_W-1:0]   list_waddr, list_raddr;
    logic [ERR_W-1:0]  list_werr, err_rd;
    logic [MAP_W-1:0]  list_wmap, map_rd;

    assign base_pix   = i_cmd.scan_cand ? r_c : r_p;
    assign target_pix = i_cmd.scan_cand ? r_p : r_c;
    assign full_dist  = r_acc[ERR_W-1:0];
    assign list_raddr = i_cmd.rd_issue ? la_addr(r_p, LA_W'(r_e))
                                       : la_addr(base_pix, LA_W'(r_si[SI_W-1:0]));

    always_comb begin
        list_we    = 1'b0;
        list_waddr = la_addr(r_p, LA_W'(r_e));
        list_werr  = r_ierr;
        list_wmap  = r_imap;
        if (i_cmd.wr_list) begin
            list_we = p_ok && en_ok;
        end else if (i_cmd.place_worst) begin
            list_we    = 1'b1;
            list_waddr = la_addr(base_pix, LA_W'(r_wi));
            list_werr  = r_e0;
            list_wmap  = r_m0;
        end else if (i_cmd.place_first) begin
            list_we    = 1'b1;
            list_waddr = la_addr(base_pix, '0);
            list_werr  = full_dist;
            list_wmap  = MAP_W'(target_pix);
        end
    end

    knnlu_ram #(.WIDTH(ERR_W), .DEPTH(PIXELS * MAX_NEIGHBOURS)) u_err_ram (
        .i_clk   (i_clk),
        .i_we    (list_we),
        .i_waddr (list_waddr),
        .i_wdata (list_werr),
        .i_raddr (list_raddr),
        .o_rdata (err_rd)
    );

    knnlu_ram #(.WIDTH(MAP_W), .DEPTH(PIXELS * MAX_NEIGHBOURS)) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (list_we),
        .i_waddr (list_waddr),
        .i_wdata (list_wmap),
        .i_raddr (list_raddr),
        .o_rdata (map_rd)
    );

    // List scan: duplicate search and worst slot, one slot a cycle
    logic             scan_issue;
    logic             r_sv;
    logic [SI_W-1:0]  r_ss;
    logic             r_dup;
    logic [ERR_W-1:0] r_we;

    assign scan_issue = i_cmd.scan_run && (r_si < k_eff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_si  <= '0;
            r_sv  <= 1'b0;
            r_dup <= 1'b0;
            r_wi  <= SI_W'(1);
        end else if (i_cmd.scan_start) begin
            r_si  <= '0;
            r_sv  <= 1'b0;
            r_dup <= 1'b0;
            r_wi  <= SI_W'(1);
        end else begin
            if (scan_issue) begin
                r_si <= r_si + SC_W'(1);
            end
            r_sv <= scan_issue;
            if (r_sv) begin
                if (map_rd == MAP_W'(target_pix)) begin
                    r_dup <= 1'b1;
                end
                if (err_rd > r_we) begin
                    r_wi <= r_ss;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ss <= r_si[SI_W-1:0];
        if (i_cmd.scan_start) begin
            r_we <= '0;
        end else if (r_sv) begin
            if (err_rd > r_we) begin
                r_we <= err_rd;
            end
            if (r_ss == '0) begin
                r_e0 <= err_rd;
                r_m0 <= map_rd;
            end
        end
    end

    // Term pipeline: read, absolute difference, square, accumulate
    logic                   term_issue;
    logic                   r_v1, r_v2, r_v3, r_v4;
    logic                   r_l1, r_l2, r_l3, r_l4;
    logic [MAG_W-1:0]       diff, r_mag;
    logic [SQ_W-1:0]        r_sq;

    assign term_issue = i_cmd.term_run && (r_t < nk_eff);
    assign diff = {a_rd[VALUE_WIDTH-1], a_rd} - {b_rd[VALUE_WIDTH-1], b_rd};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t  <= '0;
            {r_v1, r_v2, r_v3, r_v4} <= '0;
            {r_l1, r_l2, r_l3, r_l4} <= '0;
        end else if (i_cmd.term_start) begin
            r_t  <= '0;
            {r_v1, r_v2, r_v3, r_v4} <= '0;
            {r_l1, r_l2, r_l3, r_l4} <= '0;
        end else begin
            if (term_issue) begin
                r_t <= r_t + TC_W'(1);
            end
            r_v1 <= term_issue;
            r_l1 <= (r_t == nk_eff - TC_W'(1));
            r_v2 <= r_v1;
            r_l2 <= r_l1;
            r_v3 <= r_v2;
            r_l3 <= r_l2;
            r_v4 <= r_v3;
            r_l4 <= r_l3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag <= diff[MAG_W-1] ? (~diff + MAG_W'(1)) : diff;
        r_sq  <= SQ_W'(r_mag) * SQ_W'(r_mag);
        if (i_cmd.term_start) begin
            r_acc <= '0;
        end else if (r_v3) begin
            r_acc <= r_acc + ACC_W'(r_sq);
        end
    end

    // Pixel index modulo image height, restoring, one bit a cycle
    logic [MOD_CNT_W-1:0]   r_mcnt;
    logic [DIM_REG_W-1:0]   r_mrem;
    logic [PIX_W-1:0]       r_mp;
    logic [DIM_REG_W:0]     mod_rem2, mod_sub;

    assign mod_rem2 = {r_mrem, r_mp[PIX_W-1]};
    assign mod_sub  = mod_rem2 - {1'b0, h_eff};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mcnt <= '0;
            r_mrem <= '0;
        end else if (i_cmd.mod_start) begin
            r_mcnt <= '0;
            r_mrem <= '0;
        end else if (i_cmd.mod_run) begin
            r_mcnt <= r_mcnt + MOD_CNT_W'(1);
            r_mrem <= (mod_rem2 >= {1'b0, h_eff}) ? mod_sub[DIM_REG_W-1:0]
                                                  : mod_rem2[DIM_REG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mod_start) begin
            r_mp <= r_p;
        end else if (i_cmd.mod_run) begin
            r_mp <= {r_mp[PIX_W-2:0], 1'b0};
        end
    end

    // Result word under construction
    logic [OUTC_W-1:0] r_outcome;
    logic              r_inv;
    logic [ERR_W-1:0]  r_mdist, r_rerr;
    logic [MAP_W-1:0]  r_rmap;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_outcome <= OUT_NONE;
            r_inv     <= 1'b0;
            r_mdist   <= '0;
            r_rerr    <= '0;
            r_rmap    <= '0;
        end else begin
            if (i_cmd.set_outcome) begin
                r_outcome <= i_cmd.outcome;
                if (i_cmd.outcome == OUT_INSERTED) begin
                    r_mdist <= full_dist;
                end
            end
            if (i_cmd.set_inv) begin
                r_inv <= 1'b1;
            end
            if (i_cmd.rd_capture && p_ok && en_ok) begin
                r_rerr <= err_rd;
                r_rmap <= map_rd;
            end
        end
    end

    // Output register
    logic                  r_m_valid;
    logic [M_TDATA_W-1:0]  r_m_data;
    logic [OUTC_W-1:0]     r_m_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_m_data <= {{M_PAD_W{1'b0}}, r_rmap, r_rerr, r_mdist, r_inv};
            r_m_user <= r_outcome;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

    // Status to the sequencer
    always_comb begin
        o_sts.op        = r_op;
        o_sts.eval_ok   = p_ok && c_ok;
        o_sts.scan_done = r_sv && (SC_W'(r_ss) == k_eff - SC_W'(1));
        o_sts.dup       = r_dup;
        o_sts.term_over = r_v4 && (r_acc > ACC_W'(r_we));
        o_sts.term_fin  = r_v4 && r_l4;
        o_sts.mod_done  = (r_mcnt == MOD_STEPS);
        o_sts.border    = (DIM_REG_W'(r_p) < h_eff) || (HW_W'(r_p) > r_hw)
                          || (r_mrem == DIM_REG_W'(0)) || (r_mrem == DIM_REG_W'(1));
        o_sts.dist_over = full_dist > r_we;
        o_sts.out_free  = !r_m_valid || i_m_tready;
    end

    // A finished distance that was not pruned fits the error field
    a_dist_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_sts.term_fin && !o_sts.term_over) |-> (r_acc[ACC_W-1:ERR_W] == '0))
        else $error("accepted distance wider than the error field");

    // The worst slot found by a scan lies inside the active list
    a_worst_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sts.scan_done |=> (SC_W'(r_wi) < k_eff))
        else $error("worst slot outside the active list");

    // The remainder unit ends below the divisor after its last step
    a_mod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.mod_run && (r_mcnt == MOD_STEPS - MOD_CNT_W'(1))) |=> (r_mrem < h_eff))
        else $error("remainder not below image height");

endmodule

`default_nettype wire

/* rtl/core/knn_list_update_pruned_ssd.sv */
// An evaluate makes up to two list scans of K slots each on the list memory port, runs nK
// terms through a four-stage square-and-add pipeline and takes a remainder for the border
// test; it ends early on a duplicate, a prune or a border pixel. Words are taken one at a
// time; the next word is taken while the result waits. Reset (synchronous, active low)
// restores the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module knn_list_update_pruned_ssd
    import knnlu_pkg::*;
#(
    parameter int PIXELS         = 4096,
    parameter int MAX_KERNELS    = 32,
    parameter int MAX_NEIGHBOURS = 16,
    parameter int VALUE_WIDTH    = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    // pixel_index, candidate_index, element_index, projection_value, entry_error,
    // entry_mapping, zero fill
    input  wire logic [S_TDATA_W-1:0]  i_s_tdata,
    // operation
    input  wire logic [OP_W-1:0]       i_s_tuser,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    // inverse_inserted, match_distance, read_error, read_mapping, zero fill
    output logic [M_TDATA_W-1:0]       o_m_tdata,
    // outcome
    output logic [OUTC_W-1:0]          o_m_tuser,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    knnlu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_sts      (sts),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd)
    );

    knnlu_dpath #(
        .PIXELS         (PIXELS),
        .MAX_KERNELS    (MAX_KERNELS),
        .MAX_NEIGHBOURS (MAX_NEIGHBOURS),
        .VALUE_WIDTH    (VALUE_WIDTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_m_tready (i_m_tready),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

`default_nettype wire
